### design/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Request and response codes and the shared types for the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int unsigned KeyW     = 32;
  localparam int unsigned PayloadW = 64;

  // Bit pattern of IEEE-754 double +infinity, returned on an empty extract
  localparam logic [PayloadW-1:0] PinfBits = 64'h7FF0_0000_0000_0000;

  typedef enum logic {
    FUNC_INSERT  = 1'b0,
    FUNC_EXTRACT = 1'b1
  } spq_func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_e;

  typedef logic signed [KeyW-1:0] key_t;
  typedef logic [PayloadW-1:0]    payload_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic     push;     // sorted insert of new_key/new_payload
    logic     pop;      // shift whole chain one place towards the head
    key_t     new_key;
    payload_t new_payload;
  } spq_ctrl_t;

endpackage

`default_nettype wire

### design/spq_if.sv
// ----------------------------------------------------------------------------
// Sorted priority queue channels
// Valid/ready request and response channels of the queue.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_req_if;
  import spq_pkg::*;

  logic          valid;
  logic          ready;
  logic          func;
  logic [31:0]   key;
  logic [63:0]   payload;

  modport source (output valid, output func, output key, output payload, input ready);
  modport sink   (input valid, input func, input key, input payload, output ready);
endinterface

interface spq_rsp_if;
  import spq_pkg::*;

  logic          valid;
  logic          ready;
  logic [1:0]    status;
  logic [63:0]   payload_out;

  modport source (output valid, output status, output payload_out, input ready);
  modport sink   (input valid, input status, input payload_out, output ready);
endinterface

`default_nettype wire

### design/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted chain: holds an entry, shifts right on insert at or
// beyond the insertion point and left on extract.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire             clk_i,
  input  wire spq_ctrl_t  ctrl_i,
  input  wire             occ_i,        // slot holds a live entry
  input  wire             left_ins_i,   // left neighbour is at/after the insertion point
  input  wire key_t       left_key_i,
  input  wire payload_t   left_payload_i,
  input  wire key_t       right_key_i,
  input  wire payload_t   right_payload_i,
  output logic            ins_o,
  output key_t            key_o,
  output payload_t        payload_o
);

  key_t     key_q, key_d;
  payload_t payload_q, payload_d;

  // Strict compare keeps equal keys ahead of the new entry (FIFO on ties)
  assign ins_o = !occ_i || (key_q > ctrl_i.new_key);

  always_comb begin
    key_d     = key_q;
    payload_d = payload_q;
    if (ctrl_i.push && ins_o) begin
      if (left_ins_i) begin
        key_d     = left_key_i;
        payload_d = left_payload_i;
      end else begin
        key_d     = ctrl_i.new_key;
        payload_d = ctrl_i.new_payload;
      end
    end else if (ctrl_i.pop) begin
      key_d     = right_key_i;
      payload_d = right_payload_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    payload_q <= payload_d;
  end

  assign key_o     = key_q;
  assign payload_o = payload_q;

endmodule

`default_nettype wire

### design/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Bounded min-priority queue built as a chain of sorted cells.
// ----------------------------------------------------------------------------
// The response is registered on the edge that takes the request.
// Throughput: one insert or extract per cycle while the response is drained; every cell
//   compares its key with the new key in parallel, then the whole chain shifts together.
// A request is taken whenever the response register is free or being drained.
// Reset clears the entry count, the response valid and the status; cell contents are
//   undefined until written and no clearing pass is needed.
`default_nettype none

module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = 128
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  spq_req_if.sink     req,
  spq_rsp_if.source   rsp
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            rsp_valid_q;
  spq_status_e     status_q, status_d;
  payload_t        payload_out_q, payload_out_d;

  logic      accept, full, empty, is_insert;
  spq_ctrl_t ctrl;

  logic     occ     [CAPACITY];
  logic     ins     [CAPACITY];
  key_t     key_a   [CAPACITY];
  payload_t pay_a   [CAPACITY];

  assign req.ready = !rsp_valid_q || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign is_insert = (req.func == FUNC_INSERT);
  assign full      = (count_q == CntW'(CAPACITY));
  assign empty     = (count_q == '0);

  assign ctrl.push        = accept && is_insert && !full;
  assign ctrl.pop         = accept && !is_insert && !empty;
  assign ctrl.new_key     = key_t'(req.key);
  assign ctrl.new_payload = req.payload;

  // -------- cell chain --------
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    key_t     lkey, rkey;
    payload_t lpay, rpay;
    logic     lins;

    assign occ[g] = (count_q > CntW'(g));

    if (g == 0) begin : g_head
      assign lins = 1'b0;
      assign lkey = '0;
      assign lpay = '0;
    end else begin : g_body
      assign lins = ins[g-1];
      assign lkey = key_a[g-1];
      assign lpay = pay_a[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign rkey = key_a[g];
      assign rpay = pay_a[g];
    end else begin : g_mid
      assign rkey = key_a[g+1];
      assign rpay = pay_a[g+1];
    end

    spq_cell u_cell (
      .clk_i           (clk_i),
      .ctrl_i          (ctrl),
      .occ_i           (occ[g]),
      .left_ins_i      (lins),
      .left_key_i      (lkey),
      .left_payload_i  (lpay),
      .right_key_i     (rkey),
      .right_payload_i (rpay),
      .ins_o           (ins[g]),
      .key_o           (key_a[g]),
      .payload_o       (pay_a[g])
    );
  end

  // -------- entry count --------
  always_comb begin
    count_d = count_q;
    if (ctrl.push) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  // -------- response --------
  always_comb begin
    status_d      = ST_OK;
    payload_out_d = '0;
    if (is_insert) begin
      if (full) begin
        status_d = ST_FULL;
      end
    end else if (empty) begin
      status_d      = ST_EMPTY;
      payload_out_d = PinfBits;
    end else begin
      payload_out_d = pay_a[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
      status_q    <= ST_OK;
    end else begin
      count_q <= count_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
        status_q    <= status_d;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      payload_out_q <= payload_out_d;
    end
  end

  assign rsp.valid       = rsp_valid_q;
  assign rsp.status      = status_q;
  assign rsp.payload_out = payload_out_q;

  // -------- assertions --------
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_rsp_after_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> rsp_valid_q)
    else $error("accepted request gave no response");

  a_pop_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pop |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("extract did not decrement the count");

  a_full_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_insert && full) |=> (status_q == ST_FULL) && $stable(count_q))
    else $error("insert on full queue altered state");

  a_empty_rsp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_insert && empty) |=> (status_q == ST_EMPTY)
                                        && (payload_out_q == PinfBits))
    else $error("extract on empty queue gave wrong response");

endmodule

`default_nettype wire
